### rtl/cpd_pkg.sv
// Shared types, codes and helper functions for the command packet deframer.
`default_nettype none

package cpd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 16;
	localparam int unsigned OnesW  = 12;
	localparam int unsigned FlagsW = 4;
	localparam int unsigned DataW  = 40;

	typedef enum logic [2:0] {
		CMD_DRIVE    = 3'd0,
		CMD_SLEEP    = 3'd1,
		CMD_RESPONSE = 3'd2,
		CMD_STATUS   = 3'd3,
		CMD_UNKNOWN  = 3'd4
	} cmd_t;

	typedef enum logic [0:0] {
		KIND_BODY    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ByteW-1:0]   body_byte;
		logic [CountW-1:0]  packet_count;
		cmd_t               command;
		logic [ByteW-1:0]   body_length;
		logic               check_ok;
	} res_t;

	function automatic logic [3:0] popcount8(input logic [ByteW-1:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < ByteW; i++) begin
			n = n + {3'd0, b[i]};
		end
		return n;
	endfunction

	// priority: drive, sleep, response, status
	function automatic cmd_t decode_command(input logic [FlagsW-1:0] f);
		cmd_t c;
		priority if (f[0]) begin
			c = CMD_DRIVE;
		end else if (f[2]) begin
			c = CMD_SLEEP;
		end else if (f[3]) begin
			c = CMD_RESPONSE;
		end else if (f[1]) begin
			c = CMD_STATUS;
		end else begin
			c = CMD_UNKNOWN;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/cpd_parse.sv
// Input register and packet framing state machine with ones-count check.
`default_nettype none

module cpd_parse (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [cpd_pkg::ByteW-1:0] in_byte,
	input  wire logic                    res_ready,
	output logic                         res_valid,
	output cpd_pkg::res_t                res
);

	typedef enum logic [2:0] {
		PH_CNT_LO = 3'd0,
		PH_CNT_HI = 3'd1,
		PH_FLAGS  = 3'd2,
		PH_LEN    = 3'd3,
		PH_BODY   = 3'd4,
		PH_CHECK  = 3'd5
	} phase_t;

	logic                          v_s1;
	logic [cpd_pkg::ByteW-1:0]     b_s1;
	logic                          fire;

	phase_t                        phase_q, phase_d;
	logic [cpd_pkg::CountW-1:0]    count_q, count_d;
	logic [cpd_pkg::FlagsW-1:0]    flags_q, flags_d;
	logic [cpd_pkg::ByteW-1:0]     length_q, length_d;
	logic [cpd_pkg::ByteW-1:0]     left_q, left_d;
	logic [cpd_pkg::OnesW-1:0]     ones_q, ones_d, ones_sum;
	logic [cpd_pkg::ByteW-1:0]     left_dec;

	// a request leaves s1 whenever the result side has room
	assign fire     = v_s1 && res_ready;
	assign in_ready = !v_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			b_s1 <= in_byte;
		end
	end

	assign ones_sum = ones_q + {{(cpd_pkg::OnesW-4){1'b0}}, cpd_pkg::popcount8(b_s1)};
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		flags_d   = flags_q;
		length_d  = length_q;
		left_d    = left_q;
		ones_d    = ones_sum;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_CHECK: begin
				res_valid        = fire;
				res.kind         = cpd_pkg::KIND_SUMMARY;
				res.packet_count = count_q;
				res.command      = cpd_pkg::decode_command(flags_q);
				res.body_length  = length_q;
				res.check_ok     = (ones_q == {{(cpd_pkg::OnesW-cpd_pkg::ByteW){1'b0}}, b_s1});
				phase_d          = PH_CNT_LO;
				ones_d           = '0;
				left_d           = '0;
			end
			PH_CNT_HI: begin
				count_d = {b_s1, count_q[cpd_pkg::ByteW-1:0]};
				phase_d = PH_FLAGS;
			end
			PH_FLAGS: begin
				flags_d = b_s1[cpd_pkg::FlagsW-1:0];
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				length_d = b_s1;
				left_d   = b_s1;
				phase_d  = (b_s1 == '0) ? PH_CHECK : PH_BODY;
			end
			PH_BODY: begin
				res_valid     = fire;
				res.kind      = cpd_pkg::KIND_BODY;
				res.body_byte = b_s1;
				left_d        = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_CHECK;
				end
			end
			default: begin
				// count low byte, also taken for undefined phase codes
				count_d = {{(cpd_pkg::CountW-cpd_pkg::ByteW){1'b0}}, b_s1};
				phase_d = PH_CNT_HI;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CNT_LO;
			count_q  <= '0;
			flags_q  <= '0;
			length_q <= '0;
			left_q   <= '0;
			ones_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			flags_q  <= flags_d;
			length_q <= length_d;
			left_q   <= left_d;
			ones_q   <= ones_d;
		end
	end

	a_body_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == cpd_pkg::KIND_BODY) |-> (phase_q == PH_BODY))
		else $error("body result outside body phase");

	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_CHECK) |=> (ones_q == '0 && phase_q == PH_CNT_LO))
		else $error("summary did not restart the packet");

	a_empty_body: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_LEN && b_s1 == '0) |=> (phase_q == PH_CHECK))
		else $error("empty body did not go to check byte");

endmodule

`default_nettype wire

### rtl/cpd_obuf.sv
// Two-entry result buffer that decouples the output handshake from the parser.
`default_nettype none

module cpd_obuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cpd_pkg::res_t in_res,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cpd_pkg::res_t      out_res
);

	cpd_pkg::res_t ent_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_ready)
		else $error("result offered to a full buffer");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
		else $error("buffer pointers disagree with count");

endmodule

`default_nettype wire

### rtl/command_packet_deframer_checker_unit.sv
// Top level of the command packet deframer and ones-count checker.
// Takes one packet byte per request on s_axis and can accept a byte every cycle
// while the output buffer has room: a byte is held in the input register and is
// parsed as it leaves it, its result lands in a two-entry output buffer, and
// s_axis_tready depends only on registers. Header bytes give no result, each body
// byte gives a kind-0 result, the check byte gives a kind-1 summary with count,
// command, length and check_ok (check byte equals the ones count of all prior
// packet bytes; a count above 255 never matches).
`default_nettype none

module command_packet_deframer_checker_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [7:0] body_byte, [23:8] packet_count, [26:24] command,
	// [34:27] body_length, [35] check_ok, [39:36] zero
	output logic [cpd_pkg::DataW-1:0]        m_axis_tdata,
	output logic                             m_axis_tuser   // [0] kind
);

	logic          res_valid, res_ready;
	cpd_pkg::res_t res, out_res;

	cpd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	cpd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {4'd0, out_res.check_ok, out_res.body_length, out_res.command,
		out_res.packet_count, out_res.body_byte};

endmodule

`default_nettype wire
